// ----- sv/lrd_pkg.sv -----
`default_nettype none

package lrd_pkg;

  // Field widths of the record stream.
  localparam int unsigned SEQ_W      = 63;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned OFS_W      = 40;
  localparam int unsigned CNT_W      = 37;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HDR_CNT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 63;

  // Header layout: 4 length bytes, then 4 CRC bytes, both little endian.
  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  // CRC-32 (IEEE, reflected) constants.
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SEQUENCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 2'd1;

  // Input action codes.
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // Result kind codes.
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] record_sequence;
    logic [LEN_W-1:0] record_length;
    logic             deliver;
    logic [OFS_W-1:0] valid_bytes;
    logic [CNT_W-1:0] record_count;
    logic             clean;
  } result_t;

  // Handshake between the input register and the core.
  typedef struct packed {
    logic  valid;
    item_t item;
  } in_stage_t;

  // Handshake between the core and the result register.
  typedef struct packed {
    logic    valid;
    result_t result;
  } out_stage_t;

  // One byte step of the reflected CRC-32.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lrd_in_if.sv -----
`default_nettype none

// Input channel: one segment byte or an end-of-segment mark per request.
interface lrd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lrd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/lrd_out_if.sv -----
`default_nettype none

// Result channel: an accepted record or a segment summary per request.
interface lrd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [lrd_pkg::SEQ_W-1:0] record_sequence;
  logic [lrd_pkg::LEN_W-1:0] record_length;
  logic                      deliver;
  logic [lrd_pkg::OFS_W-1:0] valid_bytes;
  logic [lrd_pkg::CNT_W-1:0] record_count;
  logic                      clean;

  modport source (output valid, kind, record_sequence, record_length, deliver,
                  valid_bytes, record_count, clean, input ready);
  modport sink   (input valid, kind, record_sequence, record_length, deliver,
                  valid_bytes, record_count, clean, output ready);
endinterface

`default_nettype wire

// ----- sv/lrd_in_reg.sv -----
`default_nettype none

// Input register: holds one request until the core takes it.
module lrd_in_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  lrd_in_if.sink                   in_i,
  input  wire logic                take_i,
  output lrd_pkg::in_stage_t       stage_o
);

  logic           valid_q;
  lrd_pkg::item_t item_q;

  // A new request enters when the register is empty or being emptied.
  assign in_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.action    <= in_i.action;
      item_q.data_byte <= in_i.data_byte;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

`default_nettype wire

// ----- sv/lrd_out_reg.sv -----
`default_nettype none

// Result register: holds one result until the sink takes it.
module lrd_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lrd_pkg::out_stage_t stage_i,
  output logic                     free_o,
  lrd_out_if.source                out_o
);

  logic             valid_q;
  lrd_pkg::result_t result_q;

  // The slot can take a new result when it is empty or drains this cycle.
  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && stage_i.valid) begin
      result_q <= stage_i.result;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.kind            = result_q.kind;
  assign out_o.record_sequence = result_q.record_sequence;
  assign out_o.record_length   = result_q.record_length;
  assign out_o.deliver         = result_q.deliver;
  assign out_o.valid_bytes     = result_q.valid_bytes;
  assign out_o.record_count    = result_q.record_count;
  assign out_o.clean           = result_q.clean;

endmodule

`default_nettype wire

// ----- sv/lrd_core.sv -----
`default_nettype none

// Deframing core: header capture, payload CRC, record check and counters.
module lrd_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lrd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lrd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire lrd_pkg::in_stage_t                stage_i,
  output logic                                   take_o,
  input  wire logic                              free_i,
  output lrd_pkg::out_stage_t                    stage_o
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  localparam logic [lrd_pkg::SEQ_W-1:0] SEQ_MAX = {lrd_pkg::SEQ_W{1'b1}};
  localparam logic [lrd_pkg::CNT_W-1:0] CNT_MAX = {lrd_pkg::CNT_W{1'b1}};
  localparam logic [lrd_pkg::OFS_W-1:0] OFS_MAX = {lrd_pkg::OFS_W{1'b1}};

  phase_e                           phase_q, phase_d;
  logic [lrd_pkg::HDR_CNT_W-1:0]    hdr_cnt_q, hdr_cnt_d;
  logic [lrd_pkg::LEN_W-1:0]        len_q, len_d;
  logic [lrd_pkg::CRC_W-1:0]        exp_crc_q, exp_crc_d;
  logic [lrd_pkg::CRC_W-1:0]        run_crc_q, run_crc_d;
  logic [lrd_pkg::LEN_W-1:0]        seen_q, seen_d;
  logic [lrd_pkg::SEQ_W-1:0]        seq_q, seq_d;
  logic [lrd_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [lrd_pkg::OFS_W-1:0]        ofs_q, ofs_d;
  logic                             clean_q, clean_d;
  logic [lrd_pkg::SEQ_W-1:0]        base_q;
  logic [lrd_pkg::SEQ_W-1:0]        start_q;

  logic                             fin;
  logic [lrd_pkg::CRC_W-1:0]        fin_got;
  logic [lrd_pkg::CRC_W-1:0]        fin_exp;
  logic [lrd_pkg::LEN_W-1:0]        fin_len;
  logic [lrd_pkg::CRC_W-1:0]        crc_next;
  logic [lrd_pkg::LEN_W-1:0]        seen_inc;
  logic [lrd_pkg::LEN_W-1:0]        byte_shift;
  logic [lrd_pkg::LEN_W:0]          ofs_add;
  logic [lrd_pkg::OFS_W:0]          ofs_sum;
  logic                             has_res;
  lrd_pkg::result_t                 res;
  lrd_pkg::item_t                   item;

  assign item       = stage_i.item;
  assign crc_next   = lrd_pkg::crc_byte(run_crc_q, item.data_byte);
  assign seen_inc   = seen_q + 1'b1;
  assign byte_shift = {{(lrd_pkg::LEN_W-lrd_pkg::BYTE_W){1'b0}}, item.data_byte}
                      << {hdr_cnt_q[1:0], 3'b000};

  // Offset after the record: header plus payload, saturating at 40 bits.
  assign ofs_add = {1'b0, fin_len} + (lrd_pkg::LEN_W+1)'(lrd_pkg::HEADER_BYTES);
  assign ofs_sum = {1'b0, ofs_q}
                   + {{(lrd_pkg::OFS_W-lrd_pkg::LEN_W){1'b0}}, ofs_add};

  // Next state and result for the request in the input register.
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    len_d     = len_q;
    exp_crc_d = exp_crc_q;
    run_crc_d = run_crc_q;
    seen_d    = seen_q;
    seq_d     = seq_q;
    cnt_d     = cnt_q;
    ofs_d     = ofs_q;
    clean_d   = clean_q;
    fin       = 1'b0;
    fin_got   = '0;
    fin_exp   = exp_crc_q;
    fin_len   = len_q;
    has_res   = 1'b0;
    res       = '0;

    if (item.action == lrd_pkg::ACT_EOS) begin
      // End of segment: a record in flight makes the segment unclean.
      has_res          = 1'b1;
      res.kind         = lrd_pkg::KIND_SUMMARY;
      res.valid_bytes  = ofs_q;
      res.record_count = cnt_q;
      res.clean        = clean_q && !(phase_q == PH_PAYLOAD ||
                                      (phase_q == PH_HEADER && hdr_cnt_q != '0));
      phase_d   = PH_HEADER;
      hdr_cnt_d = '0;
      len_d     = '0;
      exp_crc_d = '0;
      run_crc_d = lrd_pkg::CRC_ONES;
      seen_d    = '0;
      seq_d     = base_q;
      cnt_d     = '0;
      ofs_d     = '0;
      clean_d   = 1'b1;
    end else begin
      case (phase_q)
        PH_HEADER: begin
          if (!hdr_cnt_q[2]) begin
            len_d = len_q | byte_shift;
          end else begin
            exp_crc_d = exp_crc_q | byte_shift;
          end
          if (hdr_cnt_q == lrd_pkg::HDR_LAST) begin
            hdr_cnt_d = '0;
            seen_d    = '0;
            run_crc_d = lrd_pkg::CRC_ONES;
            if (len_d == '0) begin
              // Empty payload: check right away, its CRC is zero.
              fin     = 1'b1;
              fin_got = '0;
              fin_exp = exp_crc_d;
              fin_len = len_d;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          run_crc_d = crc_next;
          seen_d    = seen_inc;
          if (seen_inc >= len_q) begin
            fin       = 1'b1;
            fin_got   = crc_next ^ lrd_pkg::CRC_ONES;
            fin_exp   = exp_crc_q;
            fin_len   = len_q;
            len_d     = '0;
            exp_crc_d = '0;
          end
        end
        default: begin
          // Stopped: bytes are dropped until end of segment.
        end
      endcase

      // Record check at the end of a record.
      if (fin) begin
        if (fin_got != fin_exp) begin
          phase_d = PH_STOPPED;
          clean_d = 1'b0;
        end else begin
          cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
          ofs_d = ofs_sum[lrd_pkg::OFS_W] ? OFS_MAX : ofs_sum[lrd_pkg::OFS_W-1:0];
          has_res             = 1'b1;
          res.kind            = lrd_pkg::KIND_RECORD;
          res.record_sequence = seq_q;
          res.record_length   = fin_len;
          res.deliver         = (seq_q >= start_q);
          res.valid_bytes     = ofs_d;
          res.record_count    = cnt_d;
          res.clean           = 1'b1;
          seq_d     = (seq_q == SEQ_MAX) ? seq_q : seq_q + 1'b1;
          phase_d   = PH_HEADER;
          hdr_cnt_d = '0;
          seen_d    = '0;
          run_crc_d = lrd_pkg::CRC_ONES;
        end
      end
    end
  end

  // A request without a result never waits for the result slot.
  assign take_o         = stage_i.valid && (!has_res || free_i);
  assign stage_o.valid  = take_o && has_res;
  assign stage_o.result = res;

  // Segment state; user writes configuration only when idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= '0;
      len_q     <= '0;
      exp_crc_q <= '0;
      run_crc_q <= lrd_pkg::CRC_ONES;
      seen_q    <= '0;
      seq_q     <= '0;
      cnt_q     <= '0;
      ofs_q     <= '0;
      clean_q   <= 1'b1;
      base_q    <= '0;
      start_q   <= '0;
    end else begin
      if (take_o) begin
        phase_q   <= phase_d;
        hdr_cnt_q <= hdr_cnt_d;
        len_q     <= len_d;
        exp_crc_q <= exp_crc_d;
        run_crc_q <= run_crc_d;
        seen_q    <= seen_d;
        seq_q     <= seq_d;
        cnt_q     <= cnt_d;
        ofs_q     <= ofs_d;
        clean_q   <= clean_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          lrd_pkg::CFG_BASE_SEQUENCE: begin
            base_q <= cfg_data_i;
            seq_q  <= cfg_data_i;
          end
          lrd_pkg::CFG_START_SEQUENCE: begin
            start_q <= cfg_data_i;
          end
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/log_record_deframer_crc32_top.sv -----
`default_nettype none

// Channel   Dir  Handshake        Payload
// in_i      in   valid / ready    action, data_byte
// out_o     out  valid / ready    kind, record_sequence, record_length, deliver,
//                                 valid_bytes, record_count, clean
// cfg       in   cfg_we_i         cfg_index_i, cfg_data_i (no read-back)
//
// A request sits in the input register while the core works on it in that same
// cycle; its result, if any, enters the result register in the cycle after the take.
// Sustained rate is one request per cycle while results drain; CRC is combinational.
// Reset is asynchronous, active low; no clearing pass follows it.
// Requests that make no result are taken every cycle even while a result is held;
// a request that makes a result waits in the input register, and so stalls the
// input, until the result register drains.
module log_record_deframer_crc32_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lrd_in_if.sink                              in_i,
  lrd_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lrd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  lrd_pkg::in_stage_t  in_stage;
  lrd_pkg::out_stage_t out_stage;
  logic                take;
  logic                free;

  lrd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .stage_o (in_stage)
  );

  lrd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (in_stage),
    .take_o      (take),
    .free_i      (free),
    .stage_o     (out_stage)
  );

  lrd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (out_stage),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
